// ===== rtl/core/integer_to_ascii_radix_assert.svh =====
// assertion macros for the integer_to_ascii_radix checker
// depends on nothing; included by the checker file
`ifndef INTEGER_TO_ASCII_RADIX_ASSERT_SVH
`define INTEGER_TO_ASCII_RADIX_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define ITOAR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itoar assertion failed");

// next-cycle implication, disabled while reset is low
`define ITOAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itoar assertion failed");

`endif

// ===== rtl/core/itoar_pkg.sv =====
// shared constants and the digit-to-character function for integer_to_ascii_radix
// depends on nothing; used by the top level and its checker
package itoar_pkg;

  localparam int VALUE_BITS_DEF = 64;
  localparam int MAX_DIGITS     = 64;
  localparam int DIGIT_AW       = 6;
  localparam int CNT_W          = 7;
  localparam int RADIX_W        = 6;
  localparam int STEP_BITS      = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN  = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX  = 6'd36;
  localparam logic [RADIX_W-1:0] DEC_SPLIT  = 6'd10;
  localparam logic [CNT_W-1:0]   DIGITS_MAX = 7'd64;

  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_MINUS   = 8'h2D;

  function automatic logic [7:0] digit_char(input logic [RADIX_W-1:0] d);
    logic [7:0] dd;
    dd = {2'b00, d};
    if (d < DEC_SPLIT) begin
      return CHAR_ZERO + dd;
    end
    return CHAR_UPPER_A + (dd - {2'b00, DEC_SPLIT});
  endfunction

endpackage

// ===== rtl/core/integer_to_ascii_radix.sv =====
// top level of the integer to ascii radix converter
// depends on itoar_pkg and itoar_ram
//
// Converts one request (a VALUE_BITS-wide integer, a signed/unsigned flag, a
// radix and a minimum digit count) into a stream of ascii digits, most
// significant first, one character per output request. Digits 10 and up use
// 'A'..'Z'. Radix is clamped to 2..36 and the minimum count saturates at 64;
// the magnitude is left-padded with '0' up to that count, the sign not
// counted. A negative signed value is sent as its magnitude with tuser high
// on the first character (the caller prints the '-'); tlast marks the final
// character. No terminator is sent. The digits are produced least
// significant first by repeated division of the magnitude by the radix: a
// restoring divider retires 8 quotient bits per cycle in ST_DIV, and each
// finished digit is written in ST_NEXT into a 64-entry digit ram. Playback
// then reads the ram backward through its registered read port; a new read
// is issued only once the previous one has landed and the output register
// can take it. A new request is taken once the last character has been
// read from the ram; the output register may still hold it.
module integer_to_ascii_radix #(
  parameter int VALUE_BITS = itoar_pkg::VALUE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [63:0] value, [69:64] radix, [76:70] min_digits, [79:77] zero
  input  logic [79:0] s_axis_tdata,
  // [0] mode
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] char_out
  output logic [7:0]  m_axis_tdata,
  // [0] lead_minus
  output logic        m_axis_tuser,
  // last character of the number
  output logic        m_axis_tlast
);

  localparam int ITERS  = (VALUE_BITS + itoar_pkg::STEP_BITS - 1) / itoar_pkg::STEP_BITS;
  localparam int DIV_W  = ITERS * itoar_pkg::STEP_BITS;
  localparam int STEP_W = (ITERS > 1) ? $clog2(ITERS) : 1;
  localparam int SB     = itoar_pkg::STEP_BITS;
  localparam int RW     = itoar_pkg::RADIX_W;
  localparam int CW     = itoar_pkg::CNT_W;
  localparam int AW     = itoar_pkg::DIGIT_AW;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_NEXT,
    ST_EMIT
  } state_e;

  state_e           state_q, state_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [RW-1:0]    rem_q, rem_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [RW-1:0]    radix_q, radix_d;
  logic [CW-1:0]    mind_q, mind_d;
  logic             neg_q, neg_d;
  logic [CW-1:0]    ndig_q, ndig_d;
  logic [CW-1:0]    emit_cnt_q, emit_cnt_d;
  logic             first_q, first_d;

  // read in flight and its side info
  logic             pend_q, pend_d;
  logic             pend_pad_q, pend_pad_d;
  logic             pend_minus_q, pend_minus_d;
  logic             pend_last_q, pend_last_d;

  // output register
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_char_q, out_char_d;
  logic             out_minus_q, out_minus_d;
  logic             out_last_q, out_last_d;

  // ram ports
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [7:0]       ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [7:0]       ram_rdata;

  // request decode
  logic [VALUE_BITS-1:0] in_val;
  logic                  in_neg;
  logic [VALUE_BITS-1:0] in_mag;
  logic [RW-1:0]         in_radix_raw;
  logic [RW-1:0]         in_radix;
  logic [CW-1:0]         in_mind_raw;
  logic [CW-1:0]         in_mind;

  // divider byte step
  logic [RW:0]      div_rem;
  logic [SB-1:0]    div_qbits;
  logic [SB-1:0]    div_chunk;

  logic             in_fire;
  logic             issue;
  logic [CW-1:0]    ndig_next;

  assign in_fire = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_val       = s_axis_tdata[VALUE_BITS-1:0];
    in_neg       = s_axis_tuser && in_val[VALUE_BITS-1];
    // most negative value wraps onto its own unsigned magnitude
    in_mag       = in_neg ? (~in_val + VALUE_BITS'(1)) : in_val;
    in_radix_raw = s_axis_tdata[69:64];
    in_mind_raw  = s_axis_tdata[76:70];
    priority if (in_radix_raw < itoar_pkg::RADIX_MIN) begin
      in_radix = itoar_pkg::RADIX_MIN;
    end else if (in_radix_raw > itoar_pkg::RADIX_MAX) begin
      in_radix = itoar_pkg::RADIX_MAX;
    end else begin
      in_radix = in_radix_raw;
    end
    in_mind = (in_mind_raw > itoar_pkg::DIGITS_MAX) ? itoar_pkg::DIGITS_MAX : in_mind_raw;
  end

  // restoring division of the top quotient byte by the radix
  always_comb begin
    div_chunk = quo_q[DIV_W-1 -: SB];
    div_rem   = {1'b0, rem_q};
    div_qbits = '0;
    for (int i = 0; i < SB; i++) begin
      div_rem = {div_rem[RW-1:0], div_chunk[SB-1-i]};
      if (div_rem >= {1'b0, radix_q}) begin
        div_rem            = div_rem - {1'b0, radix_q};
        div_qbits[SB-1-i]  = 1'b1;
      end
    end
  end

  assign ndig_next = ndig_q + CW'(1);
  assign issue     = (state_q == ST_EMIT) && !pend_q && (!out_valid_q || m_axis_tready);

  always_comb begin
    state_d      = state_q;
    quo_d        = quo_q;
    rem_d        = rem_q;
    step_d       = step_q;
    radix_d      = radix_q;
    mind_d       = mind_q;
    neg_d        = neg_q;
    ndig_d       = ndig_q;
    emit_cnt_d   = emit_cnt_q;
    first_d      = first_q;
    pend_d       = 1'b0;
    pend_pad_d   = pend_pad_q;
    pend_minus_d = pend_minus_q;
    pend_last_d  = pend_last_q;
    out_valid_d  = out_valid_q;
    out_char_d   = out_char_q;
    out_minus_d  = out_minus_q;
    out_last_d   = out_last_q;
    ram_we       = 1'b0;
    ram_waddr    = ndig_q[AW-1:0];
    ram_wdata    = itoar_pkg::digit_char(rem_q);
    ram_re       = 1'b0;
    ram_raddr    = emit_cnt_q[AW-1:0] - AW'(1);

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          quo_d   = DIV_W'(in_mag);
          rem_d   = '0;
          step_d  = '0;
          radix_d = in_radix;
          mind_d  = in_mind;
          neg_d   = in_neg;
          ndig_d  = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        quo_d  = (quo_q << SB) | DIV_W'(div_qbits);
        rem_d  = div_rem[RW-1:0];
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(ITERS - 1)) begin
          state_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        // store the finished digit, then divide again or start playback
        ram_we = 1'b1;
        ndig_d = ndig_next;
        if (quo_q == '0) begin
          emit_cnt_d = (ndig_next > mind_q) ? ndig_next : mind_q;
          first_d    = 1'b1;
          state_d    = ST_EMIT;
        end else begin
          rem_d   = '0;
          step_d  = '0;
          state_d = ST_DIV;
        end
      end
      ST_EMIT: begin
        if (issue) begin
          ram_re       = 1'b1;
          pend_d       = 1'b1;
          // positions at or above the digit count are padding zeros
          pend_pad_d   = emit_cnt_q > ndig_q;
          pend_minus_d = first_q && neg_q;
          pend_last_d  = emit_cnt_q == CW'(1);
          first_d      = 1'b0;
          emit_cnt_d   = emit_cnt_q - CW'(1);
          if (emit_cnt_q == CW'(1)) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // output register: load the ram word or a padding zero when the read lands, else drain
    if (pend_q) begin
      out_valid_d = 1'b1;
      out_char_d  = pend_pad_q ? itoar_pkg::CHAR_ZERO : ram_rdata;
      out_minus_d = pend_minus_q;
      out_last_d  = pend_last_q;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      step_q      <= '0;
      ndig_q      <= '0;
      emit_cnt_q  <= '0;
      first_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      step_q      <= step_d;
      ndig_q      <= ndig_d;
      emit_cnt_q  <= emit_cnt_d;
      first_q     <= first_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    quo_q        <= quo_d;
    rem_q        <= rem_d;
    radix_q      <= radix_d;
    mind_q       <= mind_d;
    neg_q        <= neg_d;
    pend_pad_q   <= pend_pad_d;
    pend_minus_q <= pend_minus_d;
    pend_last_q  <= pend_last_d;
    out_char_q   <= out_char_d;
    out_minus_q  <= out_minus_d;
    out_last_q   <= out_last_d;
  end

  itoar_ram #(
    .WIDTH (8),
    .DEPTH (itoar_pkg::MAX_DIGITS)
  ) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_char_q;
  assign m_axis_tuser  = out_minus_q;
  assign m_axis_tlast  = out_last_q;

endmodule

// ===== rtl/core/itoar_ram.sv =====
// generic simple dual-port ram, one write and one registered read port
// depends on nothing
module itoar_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/itoar_checker.sv =====
// port-level checker for integer_to_ascii_radix, bound to the top level
// depends on itoar_pkg and integer_to_ascii_radix_assert.svh
`include "integer_to_ascii_radix_assert.svh"

module itoar_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);

  logic in_frame_q;
  logic in_fire;
  logic out_fire;
  logic char_ok;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign char_ok  = ((m_axis_tdata >= itoar_pkg::CHAR_ZERO) &&
                     (m_axis_tdata <= itoar_pkg::CHAR_NINE)) ||
                    ((m_axis_tdata >= itoar_pkg::CHAR_UPPER_A) &&
                     (m_axis_tdata <= itoar_pkg::CHAR_UPPER_Z));

  // set between the first and the last character of a number
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
    end else if (out_fire) begin
      in_frame_q <= !m_axis_tlast;
    end
  end

  `ITOAR_ASSERT_IMPL(a_char_legal, clk_i, rst_ni, m_axis_tvalid, char_ok)
  `ITOAR_ASSERT_IMPL(a_minus_first, clk_i, rst_ni, m_axis_tvalid && in_frame_q, !m_axis_tuser)
  `ITOAR_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, in_fire, !s_axis_tready)
  `ITOAR_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

endmodule

bind integer_to_ascii_radix itoar_checker u_itoar_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ===== bench/testbench.sv =====
// self-checking testbench for integer_to_ascii_radix: directed and random conversions
// depends on itoar_pkg and the integer_to_ascii_radix rtl; reads no files
// predicts every character locally and checks it against the output stream
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // mode bit carried on the request tuser
  localparam bit MODE_UNSIGNED = 1'b0;
  localparam bit MODE_SIGNED   = 1'b1;

  // cycles without any handshake before the run is declared hung
  localparam int STALL_LIMIT   = 5000;
  localparam int REPORT_LIMIT  = 10;
  localparam int TAIL_CYCLES   = 40;

  typedef struct packed {
    logic [7:0] glyph;
    logic       minus;
    logic       last;
  } ascii_char_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  // [63:0] value, [69:64] radix, [76:70] min_digits, [79:77] zero
  logic [79:0] s_axis_tdata = '0;
  // [0] mode
  logic        s_axis_tuser = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [7:0] char_out
  logic [7:0]  m_axis_tdata;
  // [0] lead_minus
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  ascii_char_t pending_chars[$];
  int          sender_idle_pct;
  int          sink_idle_pct;
  int          requests_sent;
  int          negative_requests;
  int          chars_checked;
  int          mismatches;

  integer_to_ascii_radix #(
    .VALUE_BITS(itoar_pkg::VALUE_BITS_DEF)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // sink backpressure, redrawn every cycle
  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
  end

  // expected digit string of one request, pushed in output order
  function automatic void predict_digits(logic [63:0] value, bit mode,
                                         logic [5:0] radix, logic [6:0] min_digits);
    logic [63:0] magnitude;
    logic [63:0] base;
    logic [63:0] rem;
    logic [7:0]  reversed[itoar_pkg::MAX_DIGITS];
    int          width;
    int          count;
    bit          negative;
    ascii_char_t rec;
    base = 64'(radix);
    // out-of-range radix clamps to the nearest legal base
    if (radix < itoar_pkg::RADIX_MIN) begin
      base = 64'(itoar_pkg::RADIX_MIN);
    end else if (radix > itoar_pkg::RADIX_MAX) begin
      base = 64'(itoar_pkg::RADIX_MAX);
    end
    // pad count saturates at the digit store size
    width = (min_digits > itoar_pkg::DIGITS_MAX) ? int'(itoar_pkg::DIGITS_MAX)
                                                 : int'(min_digits);
    // most negative value wraps to 2^63, which is still right as unsigned
    negative = (mode == MODE_SIGNED) && value[itoar_pkg::VALUE_BITS_DEF-1];
    magnitude = negative ? (64'd0 - value) : value;
    count = 0;
    // zero still produces one digit
    do begin
      rem = magnitude % base;
      reversed[count] = (rem < 64'(itoar_pkg::DEC_SPLIT))
                        ? (itoar_pkg::CHAR_ZERO + 8'(rem))
                        : (itoar_pkg::CHAR_UPPER_A + 8'(rem - 64'(itoar_pkg::DEC_SPLIT)));
      count++;
      magnitude = magnitude / base;
    end while (magnitude != 0);
    while (count < width) begin
      reversed[count] = itoar_pkg::CHAR_ZERO;
      count++;
    end
    for (int k = 0; k < count; k++) begin
      rec.glyph = reversed[count - 1 - k];
      rec.minus = (k == 0) && negative;
      rec.last  = (k == count - 1);
      pending_chars.push_back(rec);
    end
  endfunction

  // drive one request from a falling edge, return at the falling edge after acceptance
  task automatic send_request(logic [63:0] value, bit mode, logic [5:0] radix,
                              logic [6:0] min_digits);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, min_digits, radix, value};
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_digits(value, mode, radix, min_digits);
    requests_sent++;
    if (mode == MODE_SIGNED && value[itoar_pkg::VALUE_BITS_DEF-1]) begin
      negative_requests++;
    end
    @(negedge clk_i);
  endtask

  // stop sending and let every expected character arrive
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_chars.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    case ($urandom_range(4))
      0: v = {$urandom, $urandom};
      1: v = 64'($urandom_range(999));
      // small negative numbers in two's complement
      2: v = 64'd0 - 64'($urandom_range(1, 1000));
      3: v = {$urandom, $urandom} >> $urandom_range(63);
      default: begin
        case ($urandom_range(3))
          0: v = 64'h8000_0000_0000_0000;
          1: v = 64'h7FFF_FFFF_FFFF_FFFF;
          2: v = '1;
          default: v = '0;
        endcase
      end
    endcase
    return v;
  endfunction

  // field extremes, clamping of radix and pad count, sign corner cases
  task automatic test_directed_cases();
    send_request(64'd0, MODE_UNSIGNED, 6'd10, 7'd0);
    send_request(64'd0, MODE_UNSIGNED, 6'd10, 7'd64);
    send_request('1, MODE_UNSIGNED, 6'd2, 7'd0);
    send_request('1, MODE_UNSIGNED, 6'd36, 7'd0);
    send_request('1, MODE_SIGNED, 6'd10, 7'd0);
    send_request(64'h8000_0000_0000_0000, MODE_SIGNED, 6'd10, 7'd0);
    send_request(64'h8000_0000_0000_0000, MODE_SIGNED, 6'd2, 7'd0);
    send_request(64'h8000_0000_0000_0000, MODE_UNSIGNED, 6'd16, 7'd0);
    send_request(64'h7FFF_FFFF_FFFF_FFFF, MODE_SIGNED, 6'd16, 7'd0);
    send_request(64'd35, MODE_UNSIGNED, 6'd36, 7'd0);
    send_request(64'hDEAD_BEEF, MODE_UNSIGNED, 6'd16, 7'd12);
    send_request(64'd9, MODE_UNSIGNED, 6'd10, 7'd1);
    // radix 0 and 1 fall back to binary, 37 and up to base 36
    send_request(64'd255, MODE_UNSIGNED, 6'd0, 7'd0);
    send_request(64'd255, MODE_UNSIGNED, 6'd1, 7'd0);
    send_request(64'd255, MODE_UNSIGNED, 6'd37, 7'd0);
    send_request(64'd1295, MODE_UNSIGNED, 6'd63, 7'd0);
    // pad counts beyond 64 saturate
    send_request(64'd42, MODE_SIGNED, 6'd10, 7'd65);
    send_request(64'd42, MODE_UNSIGNED, 6'd10, 7'd127);
    send_request(64'd0 - 64'd5, MODE_SIGNED, 6'd10, 7'd5);
    send_request(64'd1, MODE_UNSIGNED, 6'd2, 7'd0);
    send_request(64'd12345, MODE_SIGNED, 6'd8, 7'd3);
  endtask

  // mostly legal radix and short padding, now and then the full field ranges
  task automatic test_random_conversions(int count);
    logic [5:0] radix;
    logic [6:0] min_digits;
    for (int i = 0; i < count; i++) begin
      radix = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(2, 36));
      min_digits = ($urandom_range(7) == 0) ? 7'($urandom_range(127))
                                            : 7'($urandom_range(12));
      send_request(random_value(), 1'($urandom_range(1)), radix, min_digits);
    end
  endtask

  // sender holds off until the output is empty, then starts again from idle
  task automatic test_drained_restart(int count);
    for (int i = 0; i < count; i++) begin
      send_request(random_value(), 1'($urandom_range(1)), 6'($urandom_range(2, 36)),
                   7'($urandom_range(20)));
      wait_drained();
    end
  endtask

  // compare each accepted character with the oldest prediction
  always @(posedge clk_i) begin : result_checker
    ascii_char_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("unexpected character %h minus %b last %b",
                   m_axis_tdata, m_axis_tuser, m_axis_tlast);
        end
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (m_axis_tdata !== want.glyph || m_axis_tuser !== want.minus ||
            m_axis_tlast !== want.last) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT) begin
            $display("character mismatch: expected %h/%b/%b, got %h/%b/%b",
                     want.glyph, want.minus, want.last,
                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
          end
        end
      end
    end
  end

  // hang detector: any handshake on either side resets the count
  initial begin : watchdog
    int stalled_cycles;
    stalled_cycles = 0;
    while (stalled_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        stalled_cycles = 0;
      end else begin
        stalled_cycles++;
      end
    end
    $display("timeout after %0d cycles without a handshake", STALL_LIMIT);
    $display("testbench: FAIL");
    $finish;
  end

  initial begin
    requests_sent     = 0;
    negative_requests = 0;
    chars_checked     = 0;
    mismatches        = 0;
    sender_idle_pct   = 13;
    sink_idle_pct     = 50;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed_cases();
    test_random_conversions(120);
    wait_drained();

    sender_idle_pct = 50;
    sink_idle_pct   = 13;
    test_drained_restart(6);
    test_random_conversions(120);

    sender_idle_pct = 0;
    sink_idle_pct   = 0;
    test_random_conversions(110);
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d conversions (%0d negative), %0d characters checked",
             requests_sent, negative_requests, chars_checked);
    $display("%0d mismatches across three idle patterns and drained restarts", mismatches);
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/itoar_pkg.sv
rtl/core/itoar_ram.sv
rtl/core/integer_to_ascii_radix.sv
rtl/core/itoar_checker.sv
bench/testbench.sv
